// ===== rtl/pps_pkg.sv =====
package pps_pkg;

  // Sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_TASKS   = 32;
  localparam int QW          = $clog2(QUEUE_DEPTH);
  localparam int CW          = $clog2(QUEUE_DEPTH + 1);

  // Fixed field widths
  localparam int ID_W    = 5;
  localparam int LEFT_W  = 8;
  localparam int PRIO_W  = 4;
  localparam int QCNT_W  = 5;

  // Item function codes
  localparam logic FUNC_ARRIVE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [ID_W-1:0]   arrive_id;
    logic [LEFT_W-1:0] arrive_burst;
    logic [PRIO_W-1:0] arrive_priority;
  } in_t;

  typedef struct packed {
    logic              running_valid;
    logic [ID_W-1:0]   running_id;
    logic [LEFT_W-1:0] running_left;
    logic              switched;
    logic              finished;
    logic              overflow;
    logic [QCNT_W-1:0] queue_count;
  } out_t;

  // One task record, running or queued
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEFT_W-1:0] left;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic scan;
    logic pick;
    logic shift;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_tick;
    logic busy;
    logic last_unit;
    logic q_empty;
    logic scan_last;
    logic shift_done;
  } stat_t;

endpackage

// ===== rtl/pps_datapath.sv =====
module pps_datapath import pps_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  in_t    in_data,
  input  cmd_t   cmd,
  output stat_t  stat,
  output out_t   out_data
);

  // Ready queue storage, kept in queue order
  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  logic [QW-1:0] rd_addr;
  logic          we;
  logic [QW-1:0] waddr;
  entry_t        wdata;

  in_t           in_reg;
  logic          busy;
  entry_t        run;
  logic [CW-1:0] count;
  logic          sw;
  logic          fin;
  logic          ovf;
  logic [QW-1:0] scan_idx;
  logic [QW-1:0] best_idx;
  entry_t        best;
  logic [QW-1:0] sh_idx;

  logic   arrive;
  logic   preempt;
  logic   q_full;
  entry_t new_ent;

  // Decode of the latched item
  always_comb begin
    arrive  = (in_reg.func == FUNC_ARRIVE);
    new_ent = '{id: in_reg.arrive_id, left: in_reg.arrive_burst,
                prio: in_reg.arrive_priority};
    preempt = busy && (in_reg.arrive_priority < run.prio);
    q_full  = (count >= CW'(QUEUE_DEPTH));
  end

  // Status back to controller
  always_comb begin
    stat.is_tick    = (in_reg.func == FUNC_TICK);
    stat.busy       = busy;
    stat.last_unit  = (run.left <= LEFT_W'(1));
    stat.q_empty    = (count == '0);
    stat.scan_last  = ((CW'(scan_idx) + CW'(1)) == count);
    stat.shift_done = ((CW'(sh_idx) + CW'(1)) >= count);
  end

  // Memory port control: enqueue at the tail, or close the gap on dispatch
  always_comb begin
    we    = 1'b0;
    waddr = count[QW-1:0];
    wdata = new_ent;
    if (cmd.exec && arrive && busy && !q_full) begin
      we    = 1'b1;
      wdata = preempt ? run : new_ent;
    end
    if (cmd.shift && !stat.shift_done) begin
      we    = 1'b1;
      waddr = sh_idx;
      wdata = rd_data;
    end
  end

  always_comb begin
    rd_addr = '0;
    if (cmd.scan) begin
      rd_addr = scan_idx + QW'(1);
    end else if (cmd.pick) begin
      rd_addr = best_idx + QW'(1);
    end else if (cmd.shift) begin
      rd_addr = sh_idx + QW'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Scheduler control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      run   <= '0;
      count <= '0;
      sw    <= 1'b0;
      fin   <= 1'b0;
      ovf   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        sw  <= 1'b0;
        fin <= 1'b0;
        ovf <= 1'b0;
      end
      if (cmd.exec) begin
        if (arrive) begin
          if (!busy) begin
            busy <= 1'b1;
            run  <= new_ent;
            sw   <= 1'b1;
          end else begin
            if (q_full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (preempt) begin
              run <= new_ent;
              sw  <= 1'b1;
            end
          end
        end else if (busy) begin
          if (!stat.last_unit) begin
            run.left <= run.left - LEFT_W'(1);
          end else begin
            fin <= 1'b1;
            if (stat.q_empty) begin
              busy <= 1'b0;
              run  <= '0;
            end
          end
        end
      end
      if (cmd.pick) begin
        busy <= 1'b1;
        run  <= best;
        sw   <= 1'b1;
      end
      if (cmd.shift && stat.shift_done) begin
        count <= count - CW'(1);
      end
    end
  end

  // Input latch, scan pointers and result register
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      in_reg <= in_data;
    end
    if (cmd.exec) begin
      scan_idx <= '0;
    end
    // first entry always wins; later ones only on a strictly better priority
    if (cmd.scan) begin
      if (scan_idx == '0 || rd_data.prio < best.prio) begin
        best     <= rd_data;
        best_idx <= scan_idx;
      end
      scan_idx <= scan_idx + QW'(1);
    end
    if (cmd.pick) begin
      sh_idx <= best_idx;
    end
    if (cmd.shift && !stat.shift_done) begin
      sh_idx <= sh_idx + QW'(1);
    end
    if (cmd.out_load) begin
      out_data.running_valid <= busy;
      out_data.running_id    <= busy ? run.id : '0;
      out_data.running_left  <= busy ? run.left : '0;
      out_data.switched      <= sw;
      out_data.finished      <= fin;
      out_data.overflow      <= ovf;
      out_data.queue_count   <= QCNT_W'(count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (run.id == '0 && run.left == '0))
    else $error("idle run slot not cleared");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (CW'(waddr) < count || (cmd.exec && CW'(waddr) == count)))
    else $error("queue write outside occupied range");

  a_pick_after_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.pick |-> $past(cmd.scan) && $past(stat.scan_last))
    else $error("dispatch without completed scan");

endmodule

// ===== rtl/pps_ctrl.sv =====
module pps_ctrl import pps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Sequencing of one item
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.is_tick && stat.busy && stat.last_unit && !stat.q_empty) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result beat register handshake
  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while held");

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> state == S_EXEC)
    else $error("accepted beat not executed");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |=> (state == S_SCAN || state == S_PICK))
    else $error("scan left early");

endmodule

// ===== rtl/preemptive_priority_scheduler_core.sv =====
// Preemptive priority scheduler, one result beat per input beat. The input is
// stalled while an item is in work. An arrival or a tick that does not complete
// the running task goes from the execute state straight to the result state. A
// tick that completes the running task while tasks wait also dispatches the best
// one: the ready queue is a 16-deep memory with one read and one write port that
// is scanned one entry per cycle for the best priority, then closed up one entry
// per cycle behind the dispatched task. A result that cannot load while the
// previous one is held on out_stall keeps the input stalled as well.
// The block takes a new item whenever it is between items, even while the previous
// result is still held in the output register.
module preemptive_priority_scheduler_core import pps_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pps_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
